// ===== rtl/core/tvbb_pkg.sv =====
// shared types and constants for the transformed vertex bounding box
// no dependencies; used by tvbb_lane, tvbb_merge and the top level

package tvbb_pkg;

   // opcode of a request
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_VERTEX = 1'b1;

   // one lane per output axis
   localparam int NUM_AXES = 3;
   localparam int ROW_W    = 2;

   // per-cycle stage enables, bounds update enable and seed flag, shared by all lanes
   typedef struct packed {
      logic en1;
      logic en2;
      logic en3;
      logic en4;
      logic upd;
      logic seed;
   } lane_ctl_type;

endpackage

// ===== rtl/core/tvbb_lane.sv =====
// one axis lane: matrix row storage, split multiply-add pipeline, saturation
// and the running min / max for that axis; depends on tvbb_pkg

module tvbb_lane #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tvbb_pkg::lane_ctl_type         ctl,
   input  logic                           load_en,
   input  logic signed [COORD_WIDTH-1:0]  coef_x,
   input  logic signed [COORD_WIDTH-1:0]  coef_y,
   input  logic signed [COORD_WIDTH-1:0]  coef_z,
   input  logic signed [COORD_WIDTH-1:0]  offset,
   input  logic signed [COORD_WIDTH-1:0]  pos_x,
   input  logic signed [COORD_WIDTH-1:0]  pos_y,
   input  logic signed [COORD_WIDTH-1:0]  pos_z,
   output logic signed [COORD_WIDTH-1:0]  lo_next,
   output logic signed [COORD_WIDTH-1:0]  hi_next
);

   localparam int CW    = COORD_WIDTH;
   localparam int LO_W  = CW / 2;
   localparam int HI_W  = CW - LO_W;
   localparam int PROD_W = 2 * CW;
   localparam int OFF_W  = CW + FRAC_BITS;
   localparam int ACC_W  = ((PROD_W > OFF_W) ? PROD_W : OFF_W) + 2;
   localparam int SH_W   = ACC_W - FRAC_BITS;
   localparam int NT     = tvbb_pkg::NUM_AXES;

   localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

   // matrix row
   logic signed [CW-1:0] coef_ff [NT];
   logic signed [CW-1:0] off_ff;
   logic signed [CW-1:0] pos_w   [NT];

   // stage 1: partial products
   logic signed [2*HI_W-1:0] hh_in [NT];
   logic signed [2*HI_W-1:0] hh_ff [NT];
   logic signed [CW:0]       hl_in [NT];
   logic signed [CW:0]       hl_ff [NT];
   logic signed [CW:0]       lh_in [NT];
   logic signed [CW:0]       lh_ff [NT];
   logic [2*LO_W-1:0]        ll_in [NT];
   logic [2*LO_W-1:0]        ll_ff [NT];
   logic signed [CW-1:0]     off1_ff;

   // stage 2: full products
   logic signed [CW+1:0]     mid_w   [NT];
   logic signed [PROD_W-1:0] prod_in [NT];
   logic signed [PROD_W-1:0] prod_ff [NT];
   logic signed [ACC_W-1:0]  off2_in;
   logic signed [ACC_W-1:0]  off2_ff;

   // stage 3: two partial sums
   logic signed [ACC_W-1:0]  sa_in;
   logic signed [ACC_W-1:0]  sa_ff;
   logic signed [ACC_W-1:0]  sb_in;
   logic signed [ACC_W-1:0]  sb_ff;

   // stage 4: scaled, saturated coordinate
   logic signed [ACC_W-1:0]  acc_w;
   logic        [SH_W-1:0]   sh_w;
   logic                     fits_w;
   logic signed [CW-1:0]     t_in;
   logic signed [CW-1:0]     t_ff;

   logic signed [CW-1:0]     lo_ff;
   logic signed [CW-1:0]     hi_ff;

   assign pos_w[0] = pos_x;
   assign pos_w[1] = pos_y;
   assign pos_w[2] = pos_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NT; j++) begin
            coef_ff[j] <= '0;
         end
         off_ff <= '0;
      end else if (load_en) begin
         coef_ff[0] <= coef_x;
         coef_ff[1] <= coef_y;
         coef_ff[2] <= coef_z;
         off_ff     <= offset;
      end
   end

   // partial products of the halves: high halves signed, low halves unsigned
   always_comb begin
      for (int j = 0; j < NT; j++) begin
         hh_in[j] = $signed(coef_ff[j][CW-1:LO_W]) * $signed(pos_w[j][CW-1:LO_W]);
         hl_in[j] = $signed(coef_ff[j][CW-1:LO_W]) * $signed({1'b0, pos_w[j][LO_W-1:0]});
         lh_in[j] = $signed({1'b0, coef_ff[j][LO_W-1:0]}) * $signed(pos_w[j][CW-1:LO_W]);
         ll_in[j] = coef_ff[j][LO_W-1:0] * pos_w[j][LO_W-1:0];
      end
   end

   // high*high and low*low do not overlap, so they concatenate
   always_comb begin
      for (int j = 0; j < NT; j++) begin
         mid_w[j]   = $signed({hl_ff[j][CW], hl_ff[j]}) + $signed({lh_ff[j][CW], lh_ff[j]});
         prod_in[j] = $signed({hh_ff[j], ll_ff[j]})
                    + ($signed({{(CW-2){mid_w[j][CW+1]}}, mid_w[j]}) <<< LO_W);
      end
      off2_in = $signed({{(ACC_W-CW){off1_ff[CW-1]}}, off1_ff}) <<< FRAC_BITS;
   end

   always_comb begin
      sa_in = $signed({{(ACC_W-PROD_W){prod_ff[0][PROD_W-1]}}, prod_ff[0]})
            + $signed({{(ACC_W-PROD_W){prod_ff[1][PROD_W-1]}}, prod_ff[1]});
      sb_in = $signed({{(ACC_W-PROD_W){prod_ff[2][PROD_W-1]}}, prod_ff[2]}) + off2_ff;
   end

   // add the partial sums, floor shift, then clamp to the coordinate range
   always_comb begin
      acc_w  = sa_ff + sb_ff;
      sh_w   = acc_w[ACC_W-1:FRAC_BITS];
      fits_w = (&sh_w[SH_W-1:CW-1]) || (~|sh_w[SH_W-1:CW-1]);
      if (fits_w) begin
         t_in = $signed(sh_w[CW-1:0]);
      end else if (sh_w[SH_W-1]) begin
         t_in = SAT_MIN;
      end else begin
         t_in = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en1) begin
         for (int j = 0; j < NT; j++) begin
            hh_ff[j] <= hh_in[j];
            hl_ff[j] <= hl_in[j];
            lh_ff[j] <= lh_in[j];
            ll_ff[j] <= ll_in[j];
         end
         off1_ff <= off_ff;
      end
      if (ctl.en2) begin
         for (int j = 0; j < NT; j++) begin
            prod_ff[j] <= prod_in[j];
         end
         off2_ff <= off2_in;
      end
      if (ctl.en3) begin
         sa_ff <= sa_in;
         sb_ff <= sb_in;
      end
      if (ctl.en4) begin
         t_ff <= t_in;
      end
   end

   assign lo_next = (ctl.seed || (t_ff < lo_ff)) ? t_ff : lo_ff;
   assign hi_next = (ctl.seed || (hi_ff < t_ff)) ? t_ff : hi_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lo_ff <= '0;
         hi_ff <= '0;
      end else if (ctl.upd) begin
         lo_ff <= lo_next;
         hi_ff <= hi_next;
      end
   end

endmodule

// ===== rtl/core/tvbb_merge.sv =====
// merge stage: gathers the three lanes' bounds into the response register
// depends on tvbb_pkg

module tvbb_merge #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  logic signed [COORD_WIDTH-1:0] lo_in [tvbb_pkg::NUM_AXES],
   input  logic signed [COORD_WIDTH-1:0] hi_in [tvbb_pkg::NUM_AXES],
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [COORD_WIDTH-1:0] rsp_min_x,
   output logic signed [COORD_WIDTH-1:0] rsp_min_y,
   output logic signed [COORD_WIDTH-1:0] rsp_min_z,
   output logic signed [COORD_WIDTH-1:0] rsp_max_x,
   output logic signed [COORD_WIDTH-1:0] rsp_max_y,
   output logic signed [COORD_WIDTH-1:0] rsp_max_z
);

   logic                          valid_ff;
   logic signed [COORD_WIDTH-1:0] min_ff [tvbb_pkg::NUM_AXES];
   logic signed [COORD_WIDTH-1:0] max_ff [tvbb_pkg::NUM_AXES];

   assign in_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         for (int j = 0; j < tvbb_pkg::NUM_AXES; j++) begin
            min_ff[j] <= lo_in[j];
            max_ff[j] <= hi_in[j];
         end
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_min_x = min_ff[0];
   assign rsp_min_y = min_ff[1];
   assign rsp_min_z = min_ff[2];
   assign rsp_max_x = max_ff[0];
   assign rsp_max_y = max_ff[1];
   assign rsp_max_z = max_ff[2];

endmodule

// ===== rtl/core/transformed_vertex_bounding_box.sv =====
// top level: affine vertex transform with running axis-aligned bounds
// depends on tvbb_pkg, tvbb_lane, tvbb_merge
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_ready | op, row, coef_x/y/z, offset, pos_x/y/z, restart
//   rsp     | out       | rsp_valid/rsp_ready | min_x/y/z, max_x/y/z
//
// one request per cycle while req_ready is high; a vertex response passes in turn through the
// partial products, products, two partial sums, scale and saturate, and merge registers
// three lanes, one per output axis, each with its own split multipliers
// row loads take effect at acceptance and produce no response
// reset clears the matrix, the bounds and the pipeline valid flags
// each stage holds under rsp stall; bubbles close up, so req_ready falls
// only once every stage is full

module transformed_vertex_bounding_box #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [tvbb_pkg::ROW_W-1:0]          req_row,
   input  logic signed [COORD_WIDTH-1:0]       req_coef_x,
   input  logic signed [COORD_WIDTH-1:0]       req_coef_y,
   input  logic signed [COORD_WIDTH-1:0]       req_coef_z,
   input  logic signed [COORD_WIDTH-1:0]       req_offset,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_x,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_y,
   input  logic signed [COORD_WIDTH-1:0]       req_pos_z,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [COORD_WIDTH-1:0]       rsp_min_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_min_y,
   output logic signed [COORD_WIDTH-1:0]       rsp_min_z,
   output logic signed [COORD_WIDTH-1:0]       rsp_max_x,
   output logic signed [COORD_WIDTH-1:0]       rsp_max_y,
   output logic signed [COORD_WIDTH-1:0]       rsp_max_z
);

   localparam int NT = tvbb_pkg::NUM_AXES;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic r1_ff, r2_ff, r3_ff, r4_ff;
   logic seen_ff;
   logic rdy1, rdy2, rdy3, rdy4;
   logic merge_ready;
   logic req_fire;
   logic [NT-1:0] load_en;
   tvbb_pkg::lane_ctl_type ctl;

   logic signed [COORD_WIDTH-1:0] lane_lo [NT];
   logic signed [COORD_WIDTH-1:0] lane_hi [NT];

   assign rdy4      = !v4_ff || merge_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign req_fire  = req_valid && rdy1;

   assign ctl.en1  = rdy1;
   assign ctl.en2  = rdy2;
   assign ctl.en3  = rdy3;
   assign ctl.en4  = rdy4;
   assign ctl.upd  = v4_ff && merge_ready;
   // the first vertex since reset, or a flagged one, seeds the bounds
   assign ctl.seed = !seen_ff || r4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         v4_ff   <= 1'b0;
         seen_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid && (req_op == tvbb_pkg::OP_VERTEX);
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (ctl.upd) seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1) r1_ff <= req_restart;
      if (rdy2) r2_ff <= r1_ff;
      if (rdy3) r3_ff <= r2_ff;
      if (rdy4) r4_ff <= r3_ff;
   end

   for (genvar i = 0; i < NT; i++) begin : g_lane
      // a load with an out-of-range row matches no lane
      assign load_en[i] = req_fire && (req_op == tvbb_pkg::OP_LOAD)
                        && (req_row == tvbb_pkg::ROW_W'(i));

      tvbb_lane #(
         .COORD_WIDTH (COORD_WIDTH),
         .FRAC_BITS   (FRAC_BITS)
      ) u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .load_en (load_en[i]),
         .coef_x  (req_coef_x),
         .coef_y  (req_coef_y),
         .coef_z  (req_coef_z),
         .offset  (req_offset),
         .pos_x   (req_pos_x),
         .pos_y   (req_pos_y),
         .pos_z   (req_pos_z),
         .lo_next (lane_lo[i]),
         .hi_next (lane_hi[i])
      );
   end

   tvbb_merge #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_ready  (merge_ready),
      .lo_in     (lane_lo),
      .hi_in     (lane_hi),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_min_x (rsp_min_x),
      .rsp_min_y (rsp_min_y),
      .rsp_min_z (rsp_min_z),
      .rsp_max_x (rsp_max_x),
      .rsp_max_y (rsp_max_y),
      .rsp_max_z (rsp_max_z)
   );

endmodule
